[hdl/rar_pkg.sv]
// Package for the fraction add/reduce block: widths, codes, states and control structs.
package rar_pkg;

    // Field widths
    localparam int NUM_W     = 16;
    localparam int DEN_W     = 15;
    localparam int RES_NUM_W = 32;
    localparam int RES_DEN_W = 31;

    // Internal widths
    localparam int PROD_W    = 2 * DEN_W;
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int K_W       = $clog2(PROD_W + 1);

    // Operation codes carried by the mode field
    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_INC = 1'b1;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_GCD,
        ST_GSET,
        ST_DIVN_GO,
        ST_DIVN,
        ST_DIVD_GO,
        ST_DIVD,
        ST_WRITE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic mul;
        logic sum;
        logic gcd_step;
        logic g_load;
        logic div_start;
        logic div_sel_den;
        logic qn_load;
        logic qd_load;
        logic out_load;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic mode;
        logic zero;
        logic gcd_done;
        logic div_busy;
        logic out_free;
    } t_stat;

endpackage

[hdl/rar_if.sv]
// Valid/ready channel interfaces for the input and result beats.
interface rar_in_if
    import rar_pkg::*;
    ();
    logic                    valid;
    logic                    ready;
    logic                    mode;
    logic signed [NUM_W-1:0] a_numerator;
    logic [DEN_W-1:0]        a_denominator;
    logic signed [NUM_W-1:0] b_numerator;
    logic [DEN_W-1:0]        b_denominator;

    modport source (
        output valid, mode, a_numerator, a_denominator, b_numerator, b_denominator,
        input  ready
    );
    modport sink (
        input  valid, mode, a_numerator, a_denominator, b_numerator, b_denominator,
        output ready
    );
endinterface

interface rar_out_if
    import rar_pkg::*;
    ();
    logic                        valid;
    logic                        ready;
    logic signed [RES_NUM_W-1:0] result_numerator;
    logic [RES_DEN_W-1:0]        result_denominator;

    modport source (
        output valid, result_numerator, result_denominator,
        input  ready
    );
    modport sink (
        input  valid, result_numerator, result_denominator,
        output ready
    );
endinterface

[hdl/rar_div.sv]
// Restoring divider, one quotient bit per cycle.
module rar_div
    import rar_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [DIV_W-1:0] o_quotient
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W:0]       r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_W-1:0]     r_dvs;

    logic [DIV_W:0]       w_rem_sh;
    logic                 w_fit;

    // Shift in next dividend bit and try the subtract
    assign w_rem_sh = {r_rem[DIV_W-1:0], r_quo[DIV_W-1]};
    assign w_fit    = (w_rem_sh >= {1'b0, r_dvs});

    // Control: busy flag and bit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? (w_rem_sh - {1'b0, r_dvs}) : w_rem_sh;
            r_quo <= {r_quo[DIV_W-2:0], w_fit};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

[hdl/rar_dpath.sv]
// Datapath: operand capture, cross products, binary gcd, division and result register.
module rar_dpath
    import rar_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_mode,
    input  logic signed [NUM_W-1:0]     i_a_num,
    input  logic [DEN_W-1:0]            i_a_den,
    input  logic signed [NUM_W-1:0]     i_b_num,
    input  logic [DEN_W-1:0]            i_b_den,
    input  t_cmd                        i_cmd,
    output t_stat                       o_stat,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic signed [RES_NUM_W-1:0] o_res_num,
    output logic [RES_DEN_W-1:0]        o_res_den
);

    // Captured operands
    logic                        r_mode;
    logic signed [NUM_W-1:0]     r_an;
    logic [DEN_W-1:0]            r_ad;
    logic signed [NUM_W-1:0]     r_bn;
    logic [DEN_W-1:0]            r_bd;

    // Products and sum
    logic signed [RES_NUM_W-1:0] r_p1;
    logic signed [RES_NUM_W-1:0] r_p2;
    logic [PROD_W-1:0]           r_den;
    logic signed [RES_NUM_W-1:0] w_sum;
    logic                        r_neg;
    logic [DIV_W-1:0]            r_mag;

    // Gcd state
    logic [DIV_W-1:0]            r_u;
    logic [DIV_W-1:0]            r_v;
    logic [K_W-1:0]              r_k;
    logic [DIV_W-1:0]            r_g;
    logic [DIV_W-1:0]            n_u;
    logic [DIV_W-1:0]            n_v;
    logic [K_W-1:0]              n_k;
    logic [DIV_W-1:0]            w_g;

    // Division and results
    logic [DIV_W-1:0]            w_dividend;
    logic                        w_div_busy;
    logic [DIV_W-1:0]            w_quo;
    logic signed [RES_NUM_W-1:0] r_rn;
    logic [RES_DEN_W-1:0]        r_rd;
    logic                        r_ov;
    logic signed [RES_NUM_W-1:0] r_res_num;
    logic [RES_DEN_W-1:0]        r_res_den;

    // Operand capture on an input beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_an   <= i_a_num;
            r_ad   <= i_a_den;
            r_bn   <= i_b_num;
            r_bd   <= i_b_den;
        end
    end

    // Cross products and denominator product
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_p1  <= RES_NUM_W'(r_an) * RES_NUM_W'($signed({1'b0, r_bd}));
            r_p2  <= RES_NUM_W'(r_bn) * RES_NUM_W'($signed({1'b0, r_ad}));
            r_den <= PROD_W'(r_ad) * PROD_W'(r_bd);
        end
    end

    assign w_sum = r_p1 + r_p2;

    // One binary gcd step: strip twos, or subtract the smaller odd value
    always_comb begin
        n_u = r_u;
        n_v = r_v;
        n_k = r_k;
        if (!r_u[0] && !r_v[0]) begin
            n_u = r_u >> 1;
            n_v = r_v >> 1;
            n_k = r_k + 1'b1;
        end else if (!r_u[0]) begin
            n_u = r_u >> 1;
        end else if (!r_v[0]) begin
            n_v = r_v >> 1;
        end else if (r_u >= r_v) begin
            n_u = (r_u - r_v) >> 1;
        end else begin
            n_v = (r_v - r_u) >> 1;
        end
    end

    assign w_g = (r_u | r_v) << r_k;

    // Sum, gcd and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_neg <= w_sum[RES_NUM_W-1];
            r_mag <= w_sum[RES_NUM_W-1] ? DIV_W'(-w_sum) : DIV_W'(w_sum);
            r_u   <= w_sum[RES_NUM_W-1] ? DIV_W'(-w_sum) : DIV_W'(w_sum);
            r_v   <= DIV_W'(r_den);
            r_k   <= '0;
            if (r_mode == MODE_INC) begin
                r_rn <= RES_NUM_W'(r_an) + $signed({{(RES_NUM_W-DEN_W){1'b0}}, r_ad});
                r_rd <= RES_DEN_W'(r_ad);
            end else begin
                // zero sum reads as 0/1
                r_rn <= '0;
                r_rd <= RES_DEN_W'(1);
            end
        end
        if (i_cmd.gcd_step) begin
            r_u <= n_u;
            r_v <= n_v;
            r_k <= n_k;
        end
        if (i_cmd.g_load) begin
            r_g <= w_g;
        end
        if (i_cmd.qn_load) begin
            r_rn <= r_neg ? -$signed(w_quo) : $signed(w_quo);
        end
        if (i_cmd.qd_load) begin
            r_rd <= w_quo[RES_DEN_W-1:0];
        end
    end

    // Shared divider: numerator magnitude first, then denominator
    assign w_dividend = i_cmd.div_sel_den ? DIV_W'(r_den) : r_mag;

    rar_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_g),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_res_num <= r_rn;
            r_res_den <= r_rd;
        end
    end

    assign o_stat.mode     = r_mode;
    assign o_stat.zero     = (w_sum == '0);
    assign o_stat.gcd_done = (r_u == '0) || (r_v == '0);
    assign o_stat.div_busy = w_div_busy;
    assign o_stat.out_free = !r_ov || i_out_ready;

    assign o_out_valid = r_ov;
    assign o_res_num   = r_res_num;
    assign o_res_den   = r_res_den;

endmodule

[hdl/rar_ctrl.sv]
// Controller state machine that sequences one item through the datapath.
module rar_ctrl
    import rar_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_stat  i_stat,
    output t_cmd   o_cmd,
    output t_state o_state
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                if (i_stat.mode == MODE_INC || i_stat.zero) begin
                    n_state = ST_WRITE;
                end else begin
                    n_state = ST_GCD;
                end
            end
            ST_GCD: begin
                if (i_stat.gcd_done) begin
                    n_state = ST_GSET;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            ST_GSET: begin
                o_cmd.g_load = 1'b1;
                n_state      = ST_DIVN_GO;
            end
            ST_DIVN_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIVN;
            end
            ST_DIVN: begin
                if (!i_stat.div_busy) begin
                    o_cmd.qn_load = 1'b1;
                    n_state       = ST_DIVD_GO;
                end
            end
            ST_DIVD_GO: begin
                o_cmd.div_start   = 1'b1;
                o_cmd.div_sel_den = 1'b1;
                n_state           = ST_DIVD;
            end
            ST_DIVD: begin
                o_cmd.div_sel_den = 1'b1;
                if (!i_stat.div_busy) begin
                    o_cmd.qd_load = 1'b1;
                    n_state       = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_state = r_state;

endmodule

[hdl/rational_add_reduce.sv]
// Top level of the fraction add/reduce block: controller, datapath and checks.
//
// One item is in work at a time. Mode 1 (add one) and a zero sum go through capture, cross
// products and sum, then the write state loads the result register.
// Mode 0 with a nonzero sum goes through capture, cross products and sum, then one binary
// gcd step per cycle until u or v is zero (the gcd runs on a 32-bit magnitude against a
// 30-bit denominator), then a state to form the gcd, then two passes through the shared
// bit-serial divider (a start state, the shift steps and a state to take the quotient),
// and a write state; the gcd loop and the divider set how long an item takes. The write
// state waits until the output register is free. The result sits in an output register,
// so the next input beat is taken while a finished result still waits for ready.
module rational_add_reduce
    import rar_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    rar_in_if.sink    i_in,
    rar_out_if.source o_res
);

    t_cmd   w_cmd;
    t_stat  w_stat;
    t_state w_state;

    rar_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_state    (w_state)
    );

    rar_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (i_in.mode),
        .i_a_num     (i_in.a_numerator),
        .i_a_den     (i_in.a_denominator),
        .i_b_num     (i_in.b_numerator),
        .i_b_den     (i_in.b_denominator),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_res_num   (o_res.result_numerator),
        .o_res_den   (o_res.result_denominator)
    );

`ifndef SYNTHESIS
    // Divider is never restarted while a division runs
    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |-> !w_stat.div_busy)
        else $error("divider restarted while busy");

    // No input beat is taken while a division is in flight
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.div_busy |-> !i_in.ready)
        else $error("input ready during division");

    // A loaded result is presented on the next cycle
    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_res.valid)
        else $error("result load not presented");

    // Gcd only steps in its own state
    a_gcd_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.gcd_step |-> (w_state == ST_GCD) && !w_stat.gcd_done)
        else $error("gcd step outside gcd phase");
`endif

endmodule
